/* rtl/gradient_noise_fbm_defines.svh */
// ---------------------------------------------------------------------------
// gradient noise fbm assertion macros
// shared concurrent assertion forms, sampled on clk, quiet while rst_n is low
// ---------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_FBM_DEFINES_SVH
`define GRADIENT_NOISE_FBM_DEFINES_SVH

// condition implies property in the same cycle
`define GNF_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gnf assertion failed");

// condition implies property in the next cycle
`define GNF_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gnf assertion failed");

`endif

/* rtl/gnf_pkg.sv */
// ---------------------------------------------------------------------------
// gnf_pkg
// widths, constants, word context and arithmetic helpers of the noise block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gnf_pkg;

    // fixed point layout
    localparam int FB     = 16;
    localparam int IW     = 8;
    localparam int XW     = IW + FB;
    localparam int FW     = FB + 1;
    localparam int GW     = FB + 3;
    localparam int DW     = FB + 4;
    localparam int NW     = FB + 4;
    localparam int RW     = FB + 6;
    localparam int AW     = FB;
    localparam int SW     = FB + 12;
    localparam int OW     = FB + 4;
    localparam int PW     = 2 * FB + 8;
    localparam int GAIN_W = 16;
    localparam int OCNT_W = 4;
    localparam int OCT_W  = 5;

    // permutation table
    localparam int TBL_AW = 8;
    localparam int TBL_DW = 8;
    localparam int TBL_N  = 1 << TBL_AW;

    // pipeline depths
    localparam int OCT_STAGES  = 12;
    localparam int FADE_STAGES = 5;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] REG_NOISE_GAIN   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_RIDGED_MODE  = 2'd2;

    localparam logic [OCNT_W-1:0] OCT_RESET    = 4'd8;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd34079;
    localparam logic              RIDGED_RESET = 1'b0;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // fade polynomial 6t^2 - 15t + 10
    localparam int FADE_A = 6;
    localparam int FADE_B = 15;
    localparam int FADE_C = 10;

    // ridged recentering: *3/4 then minus 0.40
    localparam int RIDGE_MUL = 3;
    localparam int RIDGE_SH  = 2;

    localparam logic [PW-1:0]        HALF_P    = PW'(1 << (FB - 1));
    localparam logic signed [GW-1:0] ONE_G     = GW'(1 << FB);
    localparam logic signed [NW+1:0] ONE_N     = (NW + 2)'(1 << FB);
    localparam logic [AW-1:0]        AMP_INIT  = AW'(1 << (FB - 1));
    localparam logic [AW+GAIN_W:0]   GAIN_HALF = (AW + GAIN_W + 1)'(1 << (GAIN_W - 1));
    localparam logic signed [SW-1:0] RIDGE_OFS = SW'((4 * (1 << FB) + 5) / 10);
    localparam logic signed [OW-1:0] OUT_MAX   = OW'((1 << (OW - 1)) - 1);
    localparam logic signed [OW-1:0] OUT_MIN   = OW'(1 << (OW - 1));

    // context that travels with every word
    typedef struct packed {
        logic                     eval;
        logic [TBL_AW-1:0]        ld_idx;
        logic [TBL_DW-1:0]        ld_val;
        logic [XW-1:0]            x;
        logic [XW-1:0]            y;
        logic [OCT_W-1:0]         n_oct;
        logic [GAIN_W-1:0]        gain;
        logic                     ridged;
        logic [AW-1:0]            amp;
        logic signed [SW-1:0]     sum;
    } gnf_ctx_t;

    // round to nearest, ties away from zero, drop FB fraction bits
    function automatic logic signed [PW-1:0] rnd_s(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = p[PW-1] ? $unsigned(-p) : $unsigned(p);
        q = (mag + HALF_P) >> FB;
        rnd_s = p[PW-1] ? -$signed(q) : $signed(q);
    endfunction

    // same for values known to be non-negative
    function automatic logic [PW-1:0] rnd_u(input logic [PW-1:0] p);
        rnd_u = (p + HALF_P) >> FB;
    endfunction

    // one of eight corner gradients
    function automatic logic signed [GW-1:0] grad(input logic [2:0] h,
                                                  input logic signed [GW-1:0] gx,
                                                  input logic signed [GW-1:0] gy);
        case (h)
            3'd0:    grad = gx + gy;
            3'd1:    grad = gy - gx;
            3'd2:    grad = gx - gy;
            3'd3:    grad = -gx - gy;
            3'd4:    grad = gx;
            3'd5:    grad = -gx;
            3'd6:    grad = gy;
            default: grad = -gy;
        endcase
    endfunction

endpackage

/* rtl/gnf_fade.sv */
// ---------------------------------------------------------------------------
// gnf_fade
// five stage quintic fade 6t^5-15t^4+10t^3 built from t^2, t^3 and a poly
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnf_fade (
    input  logic                      clk,
    input  logic                      en,
    input  logic [gnf_pkg::FB-1:0]    t,
    output logic [gnf_pkg::FW-1:0]    fade
);

    localparam int FB = gnf_pkg::FB;
    localparam int PW = gnf_pkg::PW;

    logic [2*FB-1:0] tt_reg;
    logic [FB-1:0]   t1_reg;
    logic [FB:0]     t2_reg;
    logic [FB-1:0]   t2t_reg;
    logic [FB+3:0]   p2_reg;
    logic [2*FB:0]   t3p_reg;
    logic [FB+3:0]   p3_reg;
    logic [2*FB+4:0] fp_reg;
    logic [FB:0]     fade_reg;

    logic [FB:0]     t2_next;
    logic [FB+3:0]   p_next;
    logic [FB:0]     t3_next;
    logic [FB:0]     fade_next;

    // rounding and polynomial between the multiplies
    always_comb
    begin
        logic [PW-1:0] poly;
        logic [PW-1:0] r_t2;
        logic [PW-1:0] r_p;
        logic [PW-1:0] r_t3;
        logic [PW-1:0] r_f;
        r_t2 = gnf_pkg::rnd_u(PW'(tt_reg));
        poly = PW'(tt_reg) * PW'(gnf_pkg::FADE_A)
             + (PW'(gnf_pkg::FADE_C) << (2 * FB))
             - ((PW'(t1_reg) * PW'(gnf_pkg::FADE_B)) << FB);
        r_p  = gnf_pkg::rnd_u(poly);
        r_t3 = gnf_pkg::rnd_u(PW'(t3p_reg));
        r_f  = gnf_pkg::rnd_u(PW'(fp_reg));
        t2_next   = r_t2[FB:0];
        p_next    = r_p[FB+3:0];
        t3_next   = r_t3[FB:0];
        fade_next = r_f[FB:0];
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg   <= t * t;
            t1_reg   <= t;
            t2_reg   <= t2_next;
            t2t_reg  <= t1_reg;
            p2_reg   <= p_next;
            t3p_reg  <= t2_reg * t2t_reg;
            p3_reg   <= p2_reg;
            fp_reg   <= t3_next * p3_reg;
            fade_reg <= fade_next;
        end
    end

    assign fade = fade_reg;

endmodule

/* rtl/gnf_octave.sv */
// ---------------------------------------------------------------------------
// gnf_octave
// one noise octave: table lookups, gradients, blends, weighting and sum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnf_octave #(
    parameter int OCT_IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld_in,
    input  gnf_pkg::gnf_ctx_t  ctx_in,
    output logic               vld_out,
    output gnf_pkg::gnf_ctx_t  ctx_out
);

    localparam int FB  = gnf_pkg::FB;
    localparam int FW  = gnf_pkg::FW;
    localparam int GW  = gnf_pkg::GW;
    localparam int DW  = gnf_pkg::DW;
    localparam int NW  = gnf_pkg::NW;
    localparam int RW  = gnf_pkg::RW;
    localparam int AW  = gnf_pkg::AW;
    localparam int SW  = gnf_pkg::SW;
    localparam int PW  = gnf_pkg::PW;
    localparam int XW  = gnf_pkg::XW;
    localparam int TAW = gnf_pkg::TBL_AW;
    localparam int TDW = gnf_pkg::TBL_DW;
    localparam int GNW = gnf_pkg::GAIN_W;
    localparam int NS  = gnf_pkg::OCT_STAGES;

    // context line and valid bits
    gnf_pkg::gnf_ctx_t ctx_reg [1:NS];
    gnf_pkg::gnf_ctx_t ctx_last_next;
    logic [NS:1]       vld_reg;

    // table copies: one for the row pair, two for the corner hashes
    logic [TDW-1:0] perm_a  [gnf_pkg::TBL_N];
    logic [TDW-1:0] perm_b0 [gnf_pkg::TBL_N];
    logic [TDW-1:0] perm_b1 [gnf_pkg::TBL_N];

    logic [TAW-1:0] xi, xi_nb, yi;
    logic [FB-1:0]  xf, yf;
    logic [FW-1:0]  u_fade, v_fade;

    logic [TDW-1:0] pa_reg, pb_reg;
    logic [TAW-1:0] yi1_reg;
    logic [FB-1:0]  xf1_reg, yf1_reg, xf2_reg, yf2_reg;
    logic [TDW-1:0] haa_reg, hab_reg, hba_reg, hbb_reg;
    logic [TAW-1:0] ha_lo, ha_hi, hb_lo, hb_hi;

    logic signed [GW-1:0] gaa_reg, gba_reg, gab_reg, gbb_reg;
    logic signed [GW-1:0] gaa_next, gba_next, gab_next, gbb_next;
    logic signed [GW-1:0] alo4_reg, ahi4_reg, alo5_reg, ahi5_reg, alo6_reg, ahi6_reg;
    logic signed [DW-1:0] dlo4_reg, dhi4_reg, dlo5_reg, dhi5_reg;
    logic signed [FW+DW:0] pl_reg, ph_reg;
    logic [FW-1:0]        v6_reg, v7_reg;
    logic signed [NW-1:0] lo7_reg, hi7_reg, lo8_reg, n9_reg, n10_reg;
    logic signed [NW-1:0] lo_next, hi_next, n_next, m_val;
    logic signed [FW+NW+1:0] pn_reg;
    logic signed [2*NW-1:0]  mm_reg;
    logic signed [AW+RW:0]   cp_reg;
    logic [AW+GNW-1:0]       ap_reg;
    logic signed [RW-1:0]    nsel;

    assign xi    = ctx_in.x[XW-1:FB];
    assign yi    = ctx_in.y[XW-1:FB];
    assign xf    = ctx_in.x[FB-1:0];
    assign yf    = ctx_in.y[FB-1:0];
    assign xi_nb = xi + TAW'(1);
    assign ha_lo = pa_reg + yi1_reg;
    assign ha_hi = pa_reg + yi1_reg + TAW'(1);
    assign hb_lo = pb_reg + yi1_reg;
    assign hb_hi = pb_reg + yi1_reg + TAW'(1);

    // fade curves for both axes
    gnf_fade u_fade_x (
        .clk  (clk),
        .en   (en),
        .t    (xf),
        .fade (u_fade)
    );

    gnf_fade u_fade_y (
        .clk  (clk),
        .en   (en),
        .t    (yf),
        .fade (v_fade)
    );

    // row pair lookup, a load word writes this copy as it passes
    always_ff @(posedge clk)
    begin
        if (en && vld_in && (ctx_in.eval == gnf_pkg::CMD_LOAD))
            perm_a[ctx_in.ld_idx] <= ctx_in.ld_val;
        if (en)
        begin
            pa_reg <= perm_a[xi];
            pb_reg <= perm_a[xi_nb];
        end
    end

    // corner hash lookups
    always_ff @(posedge clk)
    begin
        if (en && vld_reg[1] && (ctx_reg[1].eval == gnf_pkg::CMD_LOAD))
        begin
            perm_b0[ctx_reg[1].ld_idx] <= ctx_reg[1].ld_val;
            perm_b1[ctx_reg[1].ld_idx] <= ctx_reg[1].ld_val;
        end
        if (en)
        begin
            haa_reg <= perm_b0[ha_lo];
            hab_reg <= perm_b0[ha_hi];
            hba_reg <= perm_b1[hb_lo];
            hbb_reg <= perm_b1[hb_hi];
        end
    end

    // corner gradients
    always_comb
    begin
        logic signed [GW-1:0] gx0, gx1, gy0, gy1;
        gx0 = $signed({{(GW-FB){1'b0}}, xf2_reg});
        gy0 = $signed({{(GW-FB){1'b0}}, yf2_reg});
        gx1 = gx0 - gnf_pkg::ONE_G;
        gy1 = gy0 - gnf_pkg::ONE_G;
        gaa_next = gnf_pkg::grad(haa_reg[2:0], gx0, gy0);
        gba_next = gnf_pkg::grad(hba_reg[2:0], gx1, gy0);
        gab_next = gnf_pkg::grad(hab_reg[2:0], gx0, gy1);
        gbb_next = gnf_pkg::grad(hbb_reg[2:0], gx1, gy1);
    end

    // blends, ridge fold and octave weighting
    always_comb
    begin
        logic signed [PW-1:0]   r_l, r_h, r_n, r_m;
        logic signed [NW+1:0]   n_abs, m_w;
        r_l = gnf_pkg::rnd_s(PW'(pl_reg));
        r_h = gnf_pkg::rnd_s(PW'(ph_reg));
        lo_next = NW'(alo6_reg) + r_l[NW-1:0];
        hi_next = NW'(ahi6_reg) + r_h[NW-1:0];
        r_n = gnf_pkg::rnd_s(PW'(pn_reg));
        n_next = lo8_reg + r_n[NW-1:0];
        n_abs = n9_reg[NW-1] ? -((NW + 2)'(n9_reg)) : (NW + 2)'(n9_reg);
        m_w = gnf_pkg::ONE_N - (n_abs <<< 1);
        m_val = m_w[NW-1:0];
        r_m = gnf_pkg::rnd_s(PW'(mm_reg));
        nsel = ctx_reg[10].ridged ? r_m[RW-1:0] : RW'(n10_reg);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yi1_reg  <= yi;
            xf1_reg  <= xf;
            yf1_reg  <= yf;
            xf2_reg  <= xf1_reg;
            yf2_reg  <= yf1_reg;
            gaa_reg  <= gaa_next;
            gba_reg  <= gba_next;
            gab_reg  <= gab_next;
            gbb_reg  <= gbb_next;
            alo4_reg <= gaa_reg;
            ahi4_reg <= gab_reg;
            dlo4_reg <= DW'(gba_reg) - DW'(gaa_reg);
            dhi4_reg <= DW'(gbb_reg) - DW'(gab_reg);
            alo5_reg <= alo4_reg;
            ahi5_reg <= ahi4_reg;
            dlo5_reg <= dlo4_reg;
            dhi5_reg <= dhi4_reg;
            pl_reg   <= $signed({1'b0, u_fade}) * dlo5_reg;
            ph_reg   <= $signed({1'b0, u_fade}) * dhi5_reg;
            alo6_reg <= alo5_reg;
            ahi6_reg <= ahi5_reg;
            v6_reg   <= v_fade;
            lo7_reg  <= lo_next;
            hi7_reg  <= hi_next;
            v7_reg   <= v6_reg;
            pn_reg   <= $signed({1'b0, v7_reg}) * ((NW + 1)'(hi7_reg) - (NW + 1)'(lo7_reg));
            lo8_reg  <= lo7_reg;
            n9_reg   <= n_next;
            mm_reg   <= m_val * m_val;
            n10_reg  <= n9_reg;
            cp_reg   <= $signed({1'b0, ctx_reg[10].amp}) * nsel;
            ap_reg   <= ctx_reg[10].amp * ctx_reg[10].gain;
        end
    end

    // sum update, amplitude step and coordinate doubling
    always_comb
    begin
        logic signed [PW-1:0] r_c;
        logic [AW+GNW:0]      a_r;
        logic                 active;
        r_c = gnf_pkg::rnd_s(PW'(cp_reg));
        a_r = ((AW + GNW + 1)'(ap_reg) + gnf_pkg::GAIN_HALF) >> GNW;
        active = (ctx_reg[NS-1].eval == gnf_pkg::CMD_EVAL)
              && (gnf_pkg::OCT_W'(OCT_IDX) < ctx_reg[NS-1].n_oct);
        ctx_last_next = ctx_reg[NS-1];
        ctx_last_next.x = {ctx_reg[NS-1].x[XW-2:0], 1'b0};
        ctx_last_next.y = {ctx_reg[NS-1].y[XW-2:0], 1'b0};
        ctx_last_next.amp = a_r[AW-1:0];
        if (active)
            ctx_last_next.sum = ctx_reg[NS-1].sum + r_c[SW-1:0];
    end

    // context line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[1] <= ctx_in;
            for (int k = 2; k < NS; k++)
                ctx_reg[k] <= ctx_reg[k-1];
            ctx_reg[NS] <= ctx_last_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:1], vld_in};
    end

    assign vld_out = vld_reg[NS];
    assign ctx_out = ctx_reg[NS];

endmodule

/* rtl/gnf_final.sv */
// ---------------------------------------------------------------------------
// gnf_final
// ridged recentering and saturation to the output range, two stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnf_final (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         vld_in,
    input  gnf_pkg::gnf_ctx_t            ctx_in,
    output logic                         vld_out,
    output logic signed [gnf_pkg::OW-1:0] value
);

    localparam int SW = gnf_pkg::SW;
    localparam int OW = gnf_pkg::OW;

    logic signed [SW+1:0] rs_reg, rs_next;
    logic                 vld1_reg, vld2_reg;
    logic signed [OW-1:0] out_reg, out_next;

    // ridged mode: sum*3/4 rounded, minus the ridge offset; else the sum as is
    always_comb
    begin
        logic signed [SW+1:0] s_ext, s3;
        logic [SW+1:0]        mag, q;
        logic signed [SW+1:0] r;
        s_ext = (SW + 2)'(ctx_in.sum);
        s3 = s_ext * (SW + 2)'(gnf_pkg::RIDGE_MUL);
        mag = s3[SW+1] ? $unsigned(-s3) : $unsigned(s3);
        q = (mag + (SW + 2)'(1 << (gnf_pkg::RIDGE_SH - 1))) >> gnf_pkg::RIDGE_SH;
        r = s3[SW+1] ? -$signed(q) : $signed(q);
        if (ctx_in.ridged)
            rs_next = r - (SW + 2)'(gnf_pkg::RIDGE_OFS);
        else
            rs_next = s_ext;
    end

    // clamp to the output range
    always_comb
    begin
        if (rs_reg > (SW + 2)'(gnf_pkg::OUT_MAX))
            out_next = gnf_pkg::OUT_MAX;
        else if (rs_reg < (SW + 2)'(gnf_pkg::OUT_MIN))
            out_next = gnf_pkg::OUT_MIN;
        else
            out_next = rs_reg[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_reg  <= rs_next;
            out_reg <= out_next;
        end
    end

    // only evaluate words make a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_in && (ctx_in.eval == gnf_pkg::CMD_EVAL);
            vld2_reg <= vld1_reg;
        end
    end

    assign vld_out = vld2_reg;
    assign value   = out_reg;

endmodule

/* rtl/gnf_outq.sv */
// ---------------------------------------------------------------------------
// gnf_outq
// two entry output queue, frees the pipeline from the output handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_noise_fbm_defines.svh"

module gnf_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic signed [gnf_pkg::OW-1:0] push_data,
    output logic                          space,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [gnf_pkg::OW-1:0] out_data
);

    localparam int OW = gnf_pkg::OW;

    logic signed [OW-1:0] data_reg [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic                 pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign space     = (cnt_reg != 2'd2);
    assign out_data  = data_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `GNF_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_reg != 2'd3)
    `GNF_ASSERT_IMPLY(a_no_overflow, cnt_reg == 2'd2, !push)
    `GNF_ASSERT_NEXT(a_drain, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1)

endmodule

/* rtl/gradient_noise_fbm.sv */
// ---------------------------------------------------------------------------
// gradient_noise_fbm
// fractal 2d gradient noise over up to MAX_OCTAVES octaves; while in_ready holds, one word a cycle
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_ready     command, entry_index, entry_value, x_coord, y_coord
//  out       out_valid / out_ready   noise_value
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one input word per cycle while in_ready is high; each octave is a 12 stage unit
//  and the units are chained
//  load words walk the same chain and write each octave's table copies in order
//  in_ready falls only when the two entry output queue is full; the whole
//  chain then holds in place
//  no clearing pass after reset: table entries read anything until loaded
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_noise_fbm #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [gnf_pkg::TBL_AW-1:0]        entry_index,
    input  logic [gnf_pkg::TBL_DW-1:0]        entry_value,
    input  logic [gnf_pkg::XW-1:0]            x_coord,
    input  logic [gnf_pkg::XW-1:0]            y_coord,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gnf_pkg::OW-1:0]     noise_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gnf_pkg::CFG_IW-1:0]        cfg_index,
    input  logic [gnf_pkg::CFG_DW-1:0]        cfg_data
);

    logic [gnf_pkg::OCNT_W-1:0] octave_count_reg;
    logic [gnf_pkg::GAIN_W-1:0] noise_gain_reg;
    logic                       ridged_mode_reg;

    logic                       en;
    logic [gnf_pkg::OCT_W-1:0]  n_oct;
    gnf_pkg::gnf_ctx_t          ctx0;
    logic [MAX_OCTAVES:0]       chain_vld;
    gnf_pkg::gnf_ctx_t          chain_ctx [MAX_OCTAVES+1];
    logic                       fin_vld;
    logic signed [gnf_pkg::OW-1:0] fin_value;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= gnf_pkg::OCT_RESET;
            noise_gain_reg   <= gnf_pkg::GAIN_RESET;
            ridged_mode_reg  <= gnf_pkg::RIDGED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gnf_pkg::REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[gnf_pkg::OCNT_W-1:0];
                gnf_pkg::REG_NOISE_GAIN:   noise_gain_reg   <= cfg_data[gnf_pkg::GAIN_W-1:0];
                gnf_pkg::REG_RIDGED_MODE:  ridged_mode_reg  <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // octave count limited to the built depth
    assign n_oct = (gnf_pkg::OCT_W'(octave_count_reg) > gnf_pkg::OCT_W'(MAX_OCTAVES))
                 ? gnf_pkg::OCT_W'(MAX_OCTAVES) : gnf_pkg::OCT_W'(octave_count_reg);

    // word context entering the chain
    always_comb
    begin
        ctx0.eval   = command;
        ctx0.ld_idx = entry_index;
        ctx0.ld_val = entry_value;
        ctx0.x      = x_coord;
        ctx0.y      = y_coord;
        ctx0.n_oct  = n_oct;
        ctx0.gain   = noise_gain_reg;
        ctx0.ridged = ridged_mode_reg;
        ctx0.amp    = gnf_pkg::AMP_INIT;
        ctx0.sum    = '0;
    end

    assign in_ready     = en;
    assign chain_vld[0] = in_valid;
    assign chain_ctx[0] = ctx0;

    // octave units
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        gnf_octave #(
            .OCT_IDX (k)
        ) u_oct (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (chain_vld[k]),
            .ctx_in  (chain_ctx[k]),
            .vld_out (chain_vld[k+1]),
            .ctx_out (chain_ctx[k+1])
        );
    end

    // recentering and clamp
    gnf_final u_final (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (chain_vld[MAX_OCTAVES]),
        .ctx_in  (chain_ctx[MAX_OCTAVES]),
        .vld_out (fin_vld),
        .value   (fin_value)
    );

    // output queue
    gnf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && fin_vld),
        .push_data (fin_value),
        .space     (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (noise_value)
    );

endmodule

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: gradient noise fbm testbench
// fills the permutation table, then drives directed and random evaluate and
// load words under several octave, gain and ridged settings; every result is
// checked against a fixed point noise predictor kept inside the bench
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 12 * 8 + 3;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             command = gnf_pkg::CMD_LOAD;
    logic [gnf_pkg::TBL_AW-1:0]       entry_index = '0;
    logic [gnf_pkg::TBL_DW-1:0]       entry_value = '0;
    logic [gnf_pkg::XW-1:0]           x_coord = '0;
    logic [gnf_pkg::XW-1:0]           y_coord = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [gnf_pkg::OW-1:0]    noise_value;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [gnf_pkg::CFG_IW-1:0]       cfg_index = gnf_pkg::REG_OCTAVE_COUNT;
    logic [gnf_pkg::CFG_DW-1:0]       cfg_data = '0;

    // bench copy of the block state
    logic [7:0]               perm_copy [0:255];
    logic [3:0]               oct_copy = gnf_pkg::OCT_RESET;
    logic [15:0]              gain_copy = gnf_pkg::GAIN_RESET;
    logic                     ridged_copy = gnf_pkg::RIDGED_RESET;

    logic signed [gnf_pkg::OW-1:0] noise_q [$];
    int                       errors = 0;
    bit                       quiet = 1'b0;

    always #2 clk = ~clk;

    gradient_noise_fbm u_top (.*);

    // ---------------- noise predictor ----------------
    function automatic longint round_shift(longint p, int sh);
        longint d;
        longint h;
        d = longint'(1) << sh;
        h = d >> 1;
        return (p >= 0) ? (p + h) / d : -((-p + h) / d);
    endfunction

    function automatic longint quintic(longint t);
        longint poly;
        longint t2;
        longint t3;
        poly = 6 * t * t - 15 * t * 65536 + 10 * 65536 * 65536;
        t2 = round_shift(t * t, 16);
        t3 = round_shift(t2 * t, 16);
        return round_shift(t3 * round_shift(poly, 16), 16);
    endfunction

    function automatic longint corner_grad(logic [7:0] h, longint gx, longint gy);
        case (h[2:0])
            3'd0:    return gx + gy;
            3'd1:    return gy - gx;
            3'd2:    return gx - gy;
            3'd3:    return -gx - gy;
            3'd4:    return gx;
            3'd5:    return -gx;
            3'd6:    return gy;
            default: return -gy;
        endcase
    endfunction

    function automatic longint mix(longint a, longint b, longint u);
        return a + round_shift(u * (b - a), 16);
    endfunction

    function automatic longint lattice_noise(logic [23:0] x, logic [23:0] y);
        logic [7:0] xi;
        logic [7:0] yi;
        logic [7:0] pa;
        logic [7:0] pb;
        longint     xf;
        longint     yf;
        longint     u;
        longint     v;
        longint     lo;
        longint     hi;
        xi = x[23:16];
        yi = y[23:16];
        xf = longint'(x[15:0]);
        yf = longint'(y[15:0]);
        u = quintic(xf);
        v = quintic(yf);
        pa = perm_copy[xi];
        pb = perm_copy[8'(xi + 8'd1)];
        lo = mix(corner_grad(perm_copy[8'(pa + yi)], xf, yf),
                 corner_grad(perm_copy[8'(pb + yi)], xf - 65536, yf), u);
        hi = mix(corner_grad(perm_copy[8'(pa + yi + 8'd1)], xf, yf - 65536),
                 corner_grad(perm_copy[8'(pb + yi + 8'd1)], xf - 65536, yf - 65536), u);
        return mix(lo, hi, v);
    endfunction

    function automatic logic signed [gnf_pkg::OW-1:0] fbm_value(logic [23:0] x,
                                                                logic [23:0] y);
        int     n_oct;
        longint acc;
        longint amp;
        longint n;
        longint m;
        logic [23:0] xs;
        logic [23:0] ys;
        acc = 0;
        amp = 32768;
        n_oct = (oct_copy > 8) ? 8 : int'(oct_copy);
        for (int i = 0; i < n_oct; i++)
        begin
            xs = x << i;
            ys = y << i;
            n = lattice_noise(xs, ys);
            if (ridged_copy)
            begin
                m = 65536 - 2 * ((n < 0) ? -n : n);
                n = round_shift(m * m, 16);
            end
            acc += round_shift(amp * n, 16);
            amp = round_shift(amp * longint'(gain_copy), 16);
        end
        if (ridged_copy)
            acc = round_shift(acc * 3, 2) - (4 * 65536 + 5) / 10;
        if (acc > 524287)
            acc = 524287;
        if (acc < -524288)
            acc = -524288;
        return gnf_pkg::OW'(acc);
    endfunction

    // ---------------- drivers ----------------
    task automatic maybe_gap(ref logic vld);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 17);
            vld = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // send one word; valid stays high on return
    task automatic send_word(logic cmd, logic [7:0] idx, logic [7:0] val,
                             logic [23:0] x, logic [23:0] y);
        @(negedge clk);
        maybe_gap(in_valid);
        in_valid = 1'b1;
        command = cmd;
        entry_index = idx;
        entry_value = val;
        x_coord = x;
        y_coord = y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == gnf_pkg::CMD_LOAD)
            perm_copy[idx] = val;
        else
            noise_q.push_back(fbm_value(x, y));
    endtask

    task automatic eval_at(logic [23:0] x, logic [23:0] y);
        send_word(gnf_pkg::CMD_EVAL, 8'($urandom()), 8'($urandom()), x, y);
    endtask

    task automatic load_entry(logic [7:0] idx, logic [7:0] val);
        send_word(gnf_pkg::CMD_LOAD, idx, val, 24'($urandom()), 24'($urandom()));
    endtask

    // wait until idle: no word pending and the chain flushed
    task automatic drain();
        int guard;
        @(negedge clk);
        in_valid = 1'b0;
        guard = 0;
        while (noise_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [gnf_pkg::CFG_IW-1:0] idx,
                             logic [gnf_pkg::CFG_DW-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            gnf_pkg::REG_OCTAVE_COUNT: oct_copy = data[3:0];
            gnf_pkg::REG_NOISE_GAIN:   gain_copy = data;
            gnf_pkg::REG_RIDGED_MODE:  ridged_copy = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_mode(logic [3:0] oct, logic [15:0] gain, logic ridged);
        write_reg(gnf_pkg::REG_OCTAVE_COUNT, gnf_pkg::CFG_DW'(oct));
        write_reg(gnf_pkg::REG_NOISE_GAIN, gain);
        write_reg(gnf_pkg::REG_RIDGED_MODE, gnf_pkg::CFG_DW'(ridged));
    endtask

    // ---------------- tests ----------------
    // shuffled permutation into every entry before any evaluate
    task automatic test_table_fill();
        logic [7:0] perm [0:255];
        logic [7:0] tmp;
        int j;
        for (int i = 0; i < 256; i++)
            perm[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            load_entry(8'(i), perm[i]);
    endtask

    // coordinate extremes, lattice points, wrap on doubling
    task automatic test_directed_points();
        eval_at(24'h000000, 24'h000000);
        eval_at(24'hFFFFFF, 24'hFFFFFF);
        eval_at(24'hFF0000, 24'h000000);
        eval_at(24'h000000, 24'hFF0000);
        eval_at(24'h008000, 24'h008000);
        eval_at(24'h00FFFF, 24'h000001);
        eval_at(24'hFF8000, 24'h7F4000);
        eval_at(24'h800000, 24'h800000);
        eval_at(24'h123456, 24'hABCDEF);
        eval_at(24'h555555, 24'hAAAAAA);
    endtask

    // octave count zero, one and above the maximum, gain and ridged extremes
    task automatic test_settings();
        logic [3:0]  octs  [6] = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd0};
        logic [15:0] gains [6] = '{16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'hFFFF, 16'd1234};
        logic        rdg   [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int s = 0; s < 6; s++)
        begin
            drain();
            set_mode(octs[s], gains[s], rdg[s]);
            eval_at(24'h000000, 24'h000000);
            eval_at(24'hFFFFFF, 24'h7FFFFF);
            eval_at(24'($urandom()), 24'($urandom()));
        end
    endtask

    // random evaluates with occasional table rewrites over random settings, last phase at reset settings
    task automatic test_random();
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            if (ph == 5)
                set_mode(4'd8, gnf_pkg::GAIN_RESET, 1'b0);
            else
                set_mode(4'($urandom_range(0, 15)), 16'($urandom()), 1'($urandom()));
            if (ph == 5)
                quiet = 1'b1;
            for (int k = 0; k < 75; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_entry(8'($urandom()), 8'($urandom()));
                else
                    eval_at(24'($urandom()), 24'($urandom()));
            end
        end
        drain();
    endtask

    // ---------------- result side ----------------
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 17) - 1;
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    // compare each word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (noise_q.size() == 0)
            begin
                $display("%0t: unexpected word noise_value=%0d", $realtime, noise_value);
                errors++;
            end
            else
            begin
                if (noise_value !== noise_q[0])
                begin
                    $display("%0t: noise_value expected %0d actual %0d",
                             $realtime, noise_q[0], noise_value);
                    errors++;
                end
                void'(noise_q.pop_front());
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
            perm_copy[i] = 8'd0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_table_fill();
        test_directed_points();
        test_settings();
        test_random();
        if (noise_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $realtime, noise_q.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
